[src/assert_macros.svh]
// assertion macros used by the top level of the frame allocator
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/bffa_pkg.sv]
// package of the bitmap first-fit frame allocator: codes, widths, types
// no dependencies
`default_nettype none
package bffa_pkg;

  localparam int unsigned FRAMES_DEF      = 1024;
  localparam int unsigned FRAME_BYTES_DEF = 4096;

  localparam int unsigned WORD_BITS = 8;   // frames per bitmap memory row
  localparam int unsigned NF_W      = 11;  // num_frames register
  localparam int unsigned IDX_W     = 12;  // frame index, holds up to 2047 plus one
  localparam int unsigned OFF_W     = 22;
  localparam int unsigned SIZE_W    = 23;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STAT_W    = 2;
  localparam logic [NF_W-1:0] NF_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE_ONE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_RANGE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_RUN    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO_SIZE = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_SCAN_BIT, ST_UPD_RD, ST_UPD_WR, ST_FIN
  } bffa_state_t;

  typedef struct packed {
    logic clr_wr;
    logic in_ready;
    logic scan_rd;
    logic scan_bit;
    logic upd_rd;
    logic upd_wr;
    logic fin;
  } bffa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic dec_scan;
    logic dec_upd;
    logic scan_found;
    logic scan_end;
    logic row_last_bit;
    logic upd_last;
    logic out_free;
  } bffa_stat_t;

endpackage
`default_nettype wire

[src/bffa_ram.sv]
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module bffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[src/bffa_ctrl.sv]
// controller state machine of the frame allocator
// depends on bffa_pkg
`default_nettype none
module bffa_ctrl
  import bffa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire bffa_stat_t stat,
  output bffa_cmd_t       cmd,
  output bffa_state_t     state
);

  bffa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (stat.in_valid) begin
          if (stat.dec_scan) state_next = ST_SCAN_RD;
          else if (stat.dec_upd) state_next = ST_UPD_RD;
          else state_next = ST_FIN;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_BIT;
      ST_SCAN_BIT: begin
        if (stat.scan_found) state_next = ST_UPD_RD;
        else if (stat.scan_end) state_next = ST_FIN;
        else if (stat.row_last_bit) state_next = ST_SCAN_RD;
      end
      ST_UPD_RD: state_next = ST_UPD_WR;
      ST_UPD_WR: state_next = stat.upd_last ? ST_FIN : ST_UPD_RD;
      ST_FIN: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:    cmd.clr_wr   = 1'b1;
      ST_IDLE:     cmd.in_ready = 1'b1;
      ST_SCAN_RD:  cmd.scan_rd  = 1'b1;
      ST_SCAN_BIT: cmd.scan_bit = 1'b1;
      ST_UPD_RD:   cmd.upd_rd   = 1'b1;
      ST_UPD_WR:   cmd.upd_wr   = 1'b1;
      ST_FIN:      cmd.fin      = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[src/bffa_dp.sv]
// datapath of the frame allocator: request decode, scan, row update, clearing pass, result register
// depends on bffa_pkg and bffa_ram
`default_nettype none
module bffa_dp
  import bffa_pkg::*;
#(
  parameter int unsigned FRAMES      = FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bffa_cmd_t           cmd,
  output bffa_stat_t               stat,
  input  wire logic                in_valid,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [OFF_W-1:0]    byte_offset,
  input  wire logic [SIZE_W-1:0]   byte_size,
  input  wire logic                cfg_valid,
  input  wire logic [NF_W-1:0]     cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic [OFF_W-1:0]         out_offset
);

  localparam int unsigned DEPTH = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LOG_B = $clog2(FRAME_BYTES);
  localparam int unsigned RSV   = FRAMES / 8;

  logic [NF_W-1:0]      nf;
  logic [AW-1:0]        clr_row;
  logic [IDX_W-1:0]     cur, hi, need, run, lim;
  logic                 set_val;
  logic [STAT_W-1:0]    st;
  logic [OFF_W-1:0]     res_off;
  logic [WORD_BITS-1:0] rdata, wdata, clr_word;
  logic [AW-1:0]        addr;
  logic [31:0]          cur32, clr32, region, end32, lo32, hi32, need32, off32;
  logic [23:0]          need_sum;
  logic [STAT_W-1:0]    dec_st;
  logic                 dec_scan, dec_upd, bit_used;
  logic [IDX_W-1:0]     dec_lo, dec_hi, run_inc, start, cur_row_end;

  // active frame limit
  always_comb begin
    if (32'(nf) > FRAMES) lim = IDX_W'(FRAMES);
    else lim = IDX_W'(nf);
  end

  always_ff @(posedge clk) begin
    if (rst) nf <= NF_RESET;
    else if (cfg_valid) nf <= cfg_data;
  end

  // request decode
  always_comb begin
    off32    = 32'(byte_offset);
    region   = 32'(lim) << LOG_B;
    end32    = off32 + 32'(byte_size);
    need_sum = 24'(byte_size) + 24'(FRAME_BYTES - 1);
    need32   = 32'(need_sum >> LOG_B);
    lo32     = off32 >> LOG_B;
    hi32     = (end32 + 32'(FRAME_BYTES - 1)) >> LOG_B;
    dec_st   = STAT_OK;
    dec_scan = 1'b0;
    dec_upd  = 1'b0;
    dec_lo   = IDX_W'(lo32);
    dec_hi   = IDX_W'(lo32) + IDX_W'(1);
    case (mode)
      MODE_ALLOC: begin
        if (byte_size == '0) dec_st = STAT_ZERO_SIZE;
        else if (need32 > 32'(lim)) dec_st = STAT_NO_RUN;
        else dec_scan = 1'b1;
      end
      MODE_FREE_ONE: begin
        if (off32 >= region) dec_st = STAT_OUTSIDE;
        else dec_upd = 1'b1;
      end
      MODE_FREE_RANGE: begin
        dec_hi = IDX_W'(hi32);
        if (off32 >= region || end32 > region) dec_st = STAT_OUTSIDE;
        else dec_upd = (byte_size != '0);
      end
      default: dec_st = STAT_OUTSIDE;
    endcase
  end

  // scan step on one frame
  assign bit_used    = rdata[cur[2:0]];
  assign run_inc     = run + IDX_W'(1);
  assign start       = cur - run;
  assign cur_row_end = {cur[IDX_W-1:3], 3'b000} + IDX_W'(WORD_BITS);

  always_ff @(posedge clk) begin
    if (cmd.in_ready && in_valid) begin
      st      <= dec_st;
      res_off <= '0;
      need    <= IDX_W'(need32);
      run     <= '0;
      cur     <= dec_scan ? '0 : dec_lo;
      hi      <= dec_hi;
      set_val <= dec_scan;
    end else if (cmd.scan_bit) begin
      if (stat.scan_found) begin
        cur     <= start;
        hi      <= start + need;
        res_off <= OFF_W'(32'(start) << LOG_B);
      end else begin
        run <= bit_used ? '0 : run_inc;
        cur <= cur + IDX_W'(1);
        if (stat.scan_end) st <= STAT_NO_RUN;
      end
    end else if (cmd.upd_wr) begin
      cur <= cur_row_end;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) clr_row <= '0;
    else if (cmd.clr_wr) clr_row <= clr_row + AW'(1);
  end

  always_comb begin
    clr32 = 32'(clr_row) << 3;
    for (int k = 0; k < WORD_BITS; k++) begin
      clr_word[k] = (clr32 + 32'(k)) < RSV;
    end
  end

  // row update: bits in [cur, hi) take set_val
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      if ({cur[IDX_W-1:3], 3'(k)} >= cur && {cur[IDX_W-1:3], 3'(k)} < hi) begin
        wdata[k] = set_val;
      end else begin
        wdata[k] = rdata[k];
      end
    end
  end

  assign cur32 = 32'(cur);
  assign addr  = cmd.clr_wr ? clr_row : cur32[AW+2:3];

  bffa_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (cmd.clr_wr | cmd.upd_wr),
    .re    (cmd.scan_rd | cmd.upd_rd),
    .addr  (addr),
    .wdata (cmd.clr_wr ? clr_word : wdata),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.fin) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status <= st;
      out_offset <= res_off;
    end
  end

  always_comb begin
    stat.clr_last     = (32'(clr_row) == DEPTH - 1);
    stat.in_valid     = in_valid;
    stat.dec_scan     = dec_scan;
    stat.dec_upd      = dec_upd;
    stat.scan_found   = !bit_used && (run_inc >= need);
    stat.scan_end     = (cur + IDX_W'(1)) >= lim;
    stat.row_last_bit = (cur[2:0] == 3'd7);
    stat.upd_last     = cur_row_end >= hi;
    stat.out_free     = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

[src/bitmap_first_fit_frame_allocator_unit.sv]
// top level of the bitmap first-fit frame allocator
// depends on bffa_pkg, bffa_ctrl, bffa_dp (and bffa_ram), assert_macros.svh
// One used/free bit per frame is kept in an 8-bit-wide ram. After reset a
// clearing pass of FRAMES/8 ram rows (one row per cycle) marks the first
// FRAMES/8 frames used; no request is taken meanwhile. One request is
// processed at a time. Allocate walks the bitmap one frame per cycle, with a
// row read before the frames of each row, up to the end of the found run (or
// up to num_frames), then marks the run with a read and a write per ram row
// touched. Free-one does one read and one write, free-range a read and a
// write per row touched; rejected requests go straight to the result. The
// result sits in an output register while the next request is already
// taken; num_frames may be written only while idle.
`default_nettype none
`include "assert_macros.svh"
module bitmap_first_fit_frame_allocator_unit
  import bffa_pkg::*;
#(
  parameter int unsigned FRAMES      = FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // byte_offset[21:0], byte_size[44:22], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // alloc_offset[21:0], zero pad
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  // num_frames register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  bffa_cmd_t   cmd;
  bffa_stat_t  stat;
  bffa_state_t state;
  logic [OFF_W-1:0] out_offset;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {2'b00, out_offset};

  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .cmd   (cmd),
    .state (state)
  );

  bffa_dp #(.FRAMES(FRAMES), .FRAME_BYTES(FRAME_BYTES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_valid    (s_axis_tvalid),
    .mode        (s_axis_tuser),
    .byte_offset (s_axis_tdata[21:0]),
    .byte_size   (s_axis_tdata[44:22]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (m_axis_tuser),
    .out_offset  (out_offset)
  );

  // a taken request leaves the block busy in the cycle after it
  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  // only a successful allocate carries a nonzero offset
  `ASSERT_ALWAYS(a_offset_ok, !(m_axis_tvalid && out_offset != '0) || m_axis_tuser == STAT_OK, "offset w/o ok")
  // no request is taken during the clearing pass
  `ASSERT_ALWAYS(a_no_take_in_clear, !(state == ST_CLEAR && s_axis_tready), "ready in clear")

endmodule
`default_nettype wire

[tb/sv/tb_bitmap_first_fit_frame_allocator_unit.sv]
// self-checking testbench of the bitmap first-fit frame allocator
// depends on bffa_pkg and bitmap_first_fit_frame_allocator_unit (with its submodules)
`timescale 1ns / 100ps
module tb_bitmap_first_fit_frame_allocator_unit;
  import bffa_pkg::*;

  localparam int unsigned FRAMES      = 1024;
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned HOLD_CYCLES = 400;

  // mode code with no operation behind it
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  offset;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // byte_offset[21:0], byte_size[44:22], zero pad
  logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // alloc_offset[21:0], zero pad
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // model state of the bitmap and the frame count register
  bit          frame_busy[FRAMES];
  logic [NF_W-1:0] managed_frames;

  alloc_result_t pending_results[$];
  int unsigned   live_off[$];
  int unsigned   live_len[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  bit          rx_hold = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned allocs_ok = 0;
  int unsigned allocs_full = 0;

  bitmap_first_fit_frame_allocator_unit #(
    .FRAMES(FRAMES),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // frames actually managed: register clipped to the bitmap size
  function automatic longint unsigned active_frames();
    return (managed_frames > FRAMES) ? FRAMES : managed_frames;
  endfunction

  function automatic longint unsigned region_bytes();
    return active_frames() * FRAME_BYTES;
  endfunction

  // applies one request to the model bitmap and returns the response
  function automatic alloc_result_t predict_request(logic [MODE_W-1:0] mode,
                                                    logic [OFF_W-1:0] off,
                                                    logic [SIZE_W-1:0] size);
    alloc_result_t     r;
    longint unsigned   lim, region, need, start, run, lo, hi, stop;
    lim    = active_frames();
    region = lim * FRAME_BYTES;
    r      = '0;
    if (mode == MODE_ALLOC) begin
      if (size == 0) begin
        r.status = STAT_ZERO_SIZE;
      end else begin
        need  = (longint'(size) + FRAME_BYTES - 1) / FRAME_BYTES;
        start = lim;
        run   = 0;
        if (need <= lim) begin
          for (longint unsigned i = 0; i < lim; i++) begin
            run = frame_busy[i] ? 0 : run + 1;
            if (run >= need) begin
              start = i + 1 - run;
              break;
            end
          end
        end
        if (start >= lim) begin
          r.status = STAT_NO_RUN;
        end else begin
          for (longint unsigned i = start; i < start + need; i++) frame_busy[i] = 1'b1;
          r.offset = OFF_W'(start * FRAME_BYTES);
        end
      end
    end else if (mode == MODE_FREE_ONE) begin
      if (off >= region) r.status = STAT_OUTSIDE;
      else frame_busy[off / FRAME_BYTES] = 1'b0;
    end else if (mode == MODE_FREE_RANGE) begin
      stop = longint'(off) + size;
      if (off >= region || stop > region) begin
        r.status = STAT_OUTSIDE;
      end else if (size != 0) begin
        lo = off / FRAME_BYTES;
        hi = (stop + FRAME_BYTES - 1) / FRAME_BYTES;
        for (longint unsigned i = lo; i < hi && i < lim; i++) frame_busy[i] = 1'b0;
      end
    end else begin
      // unused mode code is rejected
      r.status = STAT_OUTSIDE;
    end
    return r;
  endfunction

  // offers one request, waits for the transaction and records the expectation
  task automatic send_request(logic [MODE_W-1:0] mode, logic [OFF_W-1:0] off,
                              logic [SIZE_W-1:0] size);
    alloc_result_t r;
    // random sender gap; valid only dropped when a gap really follows
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, size, off};
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    r = predict_request(mode, off, size);
    pending_results.push_back(r);
    items_sent++;
    if (mode == MODE_ALLOC && r.status == STAT_OK) begin
      allocs_ok++;
      live_off.push_back(r.offset);
      live_len.push_back(size);
    end
    if (mode == MODE_ALLOC && r.status == STAT_NO_RUN) allocs_full++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // every result of the queue has come back, then the block settles
  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write only while idle
  task automatic write_frames(logic [NF_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    managed_frames = value;
  endtask

  // one random request, mostly well formed: allocations of a few frames and
  // frees of earlier allocations, with some noise over the whole field range
  task automatic send_random();
    int unsigned       pick, k;
    longint unsigned   region;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    region = region_bytes();
    pick   = $urandom_range(0, 99);
    off    = OFF_W'($urandom());
    size   = SIZE_W'($urandom());
    if (pick < 45) begin
      if ($urandom_range(0, 19) != 0) size = SIZE_W'($urandom_range(1, 6 * FRAME_BYTES));
      send_request(MODE_ALLOC, OFF_W'($urandom()), size);
    end else if (pick < 90 && live_off.size() != 0) begin
      k = $urandom_range(0, live_off.size() - 1);
      if (pick < 65) begin
        send_request(MODE_FREE_ONE,
                     OFF_W'(live_off[k] + $urandom_range(0, live_len[k] - 1)), size);
      end else begin
        send_request(MODE_FREE_RANGE, OFF_W'(live_off[k]), SIZE_W'(live_len[k]));
      end
      live_off.delete(k);
      live_len.delete(k);
    end else if (pick < 97) begin
      if (region != 0 && $urandom_range(0, 3) != 0) begin
        off  = OFF_W'($urandom_range(0, 32'(region - 1)));
        size = SIZE_W'($urandom_range(0, 3 * FRAME_BYTES));
      end
      send_request((pick & 1) ? MODE_FREE_ONE : MODE_FREE_RANGE, off, size);
    end else begin
      send_request(MODE_RESERVED, off, size);
    end
  endtask

  // result side: random stalls, long hold when asked
  always @(posedge clk) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // compares each result transaction with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %0d offset 0x%06h", $realtime,
                   m_axis_tuser, m_axis_tdata[OFF_W-1:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[OFF_W-1:0] !== want.offset ||
            m_axis_tdata[23:OFF_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result mismatch: status exp %0d got %0d, ",
                      "offset exp 0x%06h got 0x%06h"},
                     $realtime, want.status, m_axis_tuser, want.offset, m_axis_tdata);
        end
      end
    end
  end

  // directed corners with the reset region of 1024 frames
  task automatic test_field_corners();
    send_request(MODE_ALLOC, '0, '0);                   // zero size
    send_request(MODE_ALLOC, '0, 23'd1);                // lands after reserved frames
    send_request(MODE_ALLOC, '0, 23'd4096);
    send_request(MODE_ALLOC, '1, 23'd4097);             // rounds up to two frames
    send_request(MODE_ALLOC, '0, 23'd4194304);          // whole region, reserved frames busy
    send_request(MODE_ALLOC, '0, '1);                   // larger than the region
    send_request(MODE_FREE_ONE, '0, '0);                // reserved frame may be freed
    send_request(MODE_FREE_ONE, 22'h3FFFFF, '1);        // last byte of region
    send_request(MODE_FREE_RANGE, 22'h3FFFFF, 23'd2);   // runs past the end
    send_request(MODE_FREE_RANGE, 22'h3FFFFF, 23'd1);   // ends exactly at the end
    send_request(MODE_FREE_RANGE, 22'd5000, '0);        // zero length frees nothing
    send_request(MODE_FREE_RANGE, '0, 23'd4194304);     // whole region
    send_request(MODE_ALLOC, '0, 23'd4194304);          // now fits at offset zero
    send_request(MODE_ALLOC, '0, 23'd1);                // nothing left
    send_request(MODE_FREE_RANGE, 22'd4095, 23'd2);     // straddles two frames
    send_request(MODE_RESERVED, '1, '1);                // unused mode
    send_request(MODE_ALLOC, '0, 23'd8192);
    send_request(MODE_FREE_RANGE, 22'd8191, 23'd8193);  // partial frame at the start, ends on a frame boundary
  endtask

  // empty region, smallest and oversized register values
  task automatic test_frame_count();
    logic [NF_W-1:0] counts[4] = '{11'd0, 11'd8, 11'd2047, 11'd1024};
    foreach (counts[c]) begin
      write_frames(counts[c]);
      send_request(MODE_ALLOC, '0, 23'd1);
      send_request(MODE_FREE_ONE, '0, '0);
      send_request(MODE_FREE_RANGE, '0, '0);
      send_request(MODE_FREE_ONE, 22'h3FFFFF, '0);
      repeat (20) send_random();
    end
    write_frames(NF_W'($urandom_range(9, 1023)));
    repeat (20) send_random();
    write_frames(11'd1024);
  endtask

  task automatic test_random_phases();
    int unsigned idle_pct[4]  = '{0, 54, 0, 36};
    int unsigned stall_pct[4] = '{0, 0, 54, 36};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_pct[p];
      receiver_stall_pct = stall_pct[p];
      repeat (55) send_random();
      if (p == 1) write_frames(NF_W'($urandom_range(64, 1024)));
    end
  endtask

  // receiver holds off while requests keep coming, then the sender waits
  task automatic test_back_pressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      repeat (12) send_request(MODE_FREE_ONE, OFF_W'($urandom_range(0, 22'h3FFFFF)), '0);
    join
    wait_drained();
    repeat (20) send_random();
  endtask

  initial begin
    for (int i = 0; i < FRAMES; i++) frame_busy[i] = (i < FRAMES / 8);
    managed_frames = NF_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_field_corners();
    test_frame_count();
    test_random_phases();
    test_back_pressure();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d requests and %0d results over several frame counts and idle mixes",
             items_sent, results_seen);
    $display("allocations placed: %0d, refused for lack of space: %0d", allocs_ok, allocs_full);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/bffa_pkg.sv
src/bffa_ram.sv
src/bffa_ctrl.sv
src/bffa_dp.sv
src/bitmap_first_fit_frame_allocator_unit.sv
tb/sv/tb_bitmap_first_fit_frame_allocator_unit.sv
